// File: hdl/pcfk_pkg.sv
// Shared constants, types and register codes for the phase congruency block.
`default_nettype none

package pcfk_pkg;

    // Sample and lane geometry.
    localparam int SAMPLE_W    = 16;
    localparam int LANES       = 8;
    localparam int MAX_KERNELS = 8;
    localparam int MIN_KERNELS = 2;
    localparam int KCNT_W      = 4;

    // Arithmetic widths.
    localparam int SUM_W      = SAMPLE_W + 3;
    localparam int MAG_W      = SUM_W;
    localparam int SQ_W       = 2 * MAG_W - 1;
    localparam int ARG_W      = SQ_W + 1;
    localparam int FRAC_BITS  = 8;
    localparam int K2_W       = 8;
    localparam int FA_W       = 44;
    localparam int SQRT_IN_W  = 60;
    localparam int SQRT_OUT_W = SQRT_IN_W / 2;
    localparam int SQRT_STEPS = SQRT_OUT_W;
    localparam int REM_W      = SQRT_OUT_W + 2;
    localparam int NA_W       = 30;
    localparam int NUM_W      = 30;
    localparam int SUB_W      = 27;
    localparam int PC_W       = 16;
    localparam int DIV_STEPS  = PC_W;

    // Pipeline stage positions.
    localparam int ST_IN    = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_MAG   = 2;
    localparam int ST_SQ    = 3;
    localparam int ST_ARG   = 4;
    localparam int ST_SQRT0 = 5;
    localparam int ST_ADD1  = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_ADD2  = ST_ADD1 + 1;
    localparam int ST_DIV0  = ST_ADD2 + 1;
    localparam int ST_LAST  = ST_DIV0 + DIV_STEPS;
    localparam int NSTAGES  = ST_LAST + 1;

    // Configuration port.
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    typedef enum logic {
        REG_ACTIVE = 1'b0,
        REG_NOISE  = 1'b1
    } cfg_reg_t;

    localparam logic [KCNT_W-1:0] ACTIVE_RESET = 4'd8;
    localparam logic [15:0]       NOISE_RESET  = 16'd0;

    // Values that ride along with an item through the pipeline.
    typedef struct packed {
        logic [SUB_W-1:0] sub;
        logic             up;
        logic             down;
    } side_t;

endpackage

`default_nettype wire

// File: hdl/pcfk_in_if.sv
// Input channel carrying one voxel's kernel responses and gradient.
`default_nettype none

interface pcfk_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcfk_pkg::SAMPLE_W-1:0] resp_a;
    logic signed [pcfk_pkg::SAMPLE_W-1:0] resp_b;
    logic signed [pcfk_pkg::SAMPLE_W-1:0] resp_c;
    logic signed [pcfk_pkg::SAMPLE_W-1:0] resp_d;
    logic signed [pcfk_pkg::SAMPLE_W-1:0] resp_e;
    logic signed [pcfk_pkg::SAMPLE_W-1:0] resp_f;
    logic signed [pcfk_pkg::SAMPLE_W-1:0] resp_g;
    logic signed [pcfk_pkg::SAMPLE_W-1:0] resp_h;
    logic signed [pcfk_pkg::SAMPLE_W-1:0] grad_value;
    logic                                grad_present;

    modport source (
        output valid, resp_a, resp_b, resp_c, resp_d, resp_e, resp_f, resp_g, resp_h,
               grad_value, grad_present,
        input  ready
    );

    modport sink (
        input  valid, resp_a, resp_b, resp_c, resp_d, resp_e, resp_f, resp_g, resp_h,
               grad_value, grad_present,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/pcfk_out_if.sv
// Output channel carrying the phase congruency results of one voxel.
`default_nettype none

interface pcfk_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcfk_pkg::PC_W-1:0]   pc_all;
    logic [pcfk_pkg::PC_W-1:0]   pc_up;
    logic [pcfk_pkg::PC_W-1:0]   pc_down;

    modport source (
        output valid, pc_all, pc_up, pc_down,
        input  ready
    );

    modport sink (
        input  valid, pc_all, pc_up, pc_down,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/pcfk_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none

module pcfk_isqrt (
    input  wire logic                              clk,
    input  wire logic                              adv,
    input  wire logic [pcfk_pkg::SQRT_IN_W-1:0]   val,
    output logic      [pcfk_pkg::SQRT_OUT_W-1:0]  root
);

    logic [pcfk_pkg::SQRT_IN_W-1:0]  dat_reg  [pcfk_pkg::SQRT_STEPS];
    logic [pcfk_pkg::REM_W-1:0]      rem_reg  [pcfk_pkg::SQRT_STEPS];
    logic [pcfk_pkg::SQRT_OUT_W-1:0] root_reg [pcfk_pkg::SQRT_STEPS];

    for (genvar j = 0; j < pcfk_pkg::SQRT_STEPS; j++) begin : g_step
        logic [pcfk_pkg::SQRT_IN_W-1:0]  d_in;
        logic [pcfk_pkg::REM_W-1:0]      r_in;
        logic [pcfk_pkg::SQRT_OUT_W-1:0] q_in;
        logic [pcfk_pkg::REM_W+1:0]      remw;
        logic [pcfk_pkg::REM_W+1:0]      trial;
        logic                            fit;

        if (j == 0) begin : g_first
            assign d_in = val;
            assign r_in = '0;
            assign q_in = '0;
        end
        else begin : g_next
            assign d_in = dat_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign q_in = root_reg[j-1];
        end

        // Bring down the next two bits and try the digit one.
        assign remw  = {r_in, d_in[pcfk_pkg::SQRT_IN_W-1 -: 2]};
        assign trial = {2'b00, q_in, 2'b01};
        assign fit   = (remw >= trial);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dat_reg[j]  <= {d_in[pcfk_pkg::SQRT_IN_W-3:0], 2'b00};
                rem_reg[j]  <= fit ? pcfk_pkg::REM_W'(remw - trial)
                                   : remw[pcfk_pkg::REM_W-1:0];
                root_reg[j] <= {q_in[pcfk_pkg::SQRT_OUT_W-2:0], fit};
            end
        end
    end

    assign root = root_reg[pcfk_pkg::SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: hdl/pcfk_lane.sv
// One kernel lane: scaled response, mean comparison and its energy term.
`default_nettype none

module pcfk_lane (
    input  wire logic                                clk,
    input  wire logic                                adv,
    input  wire logic                                active,
    input  wire logic        [pcfk_pkg::KCNT_W-1:0]  n,
    input  wire logic signed [pcfk_pkg::SAMPLE_W-1:0] x,
    input  wire logic signed [pcfk_pkg::SUM_W-1:0]   s,
    input  wire logic        [pcfk_pkg::SQ_W-1:0]    s2,
    output logic                                     ge,
    output logic             [pcfk_pkg::SQRT_OUT_W-1:0] root
);

    localparam int NX_W = pcfk_pkg::SAMPLE_W + pcfk_pkg::KCNT_W + 1;

    logic signed [NX_W-1:0]              nx;
    logic        [NX_W-1:0]              nx_abs;
    logic        [2*pcfk_pkg::MAG_W-1:0] mag_sq;

    logic [pcfk_pkg::MAG_W-1:0] mag_reg;
    logic                       ge_reg;
    logic                       act2_reg;
    logic [pcfk_pkg::SQ_W-1:0]  nx2_reg;
    logic                       act3_reg;
    logic [pcfk_pkg::ARG_W-1:0] arg_reg;

    assign nx     = $signed({1'b0, n}) * x;
    assign nx_abs = nx[NX_W-1] ? (~nx + NX_W'(1)) : nx;
    assign mag_sq = {{pcfk_pkg::MAG_W{1'b0}}, mag_reg} * {{pcfk_pkg::MAG_W{1'b0}}, mag_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg  <= nx_abs[pcfk_pkg::MAG_W-1:0];
            ge_reg   <= active && (nx >= NX_W'(s));
            act2_reg <= active;
            nx2_reg  <= mag_sq[pcfk_pkg::SQ_W-1:0];
            act3_reg <= act2_reg;
            // Lanes beyond the active count contribute no energy.
            arg_reg  <= act3_reg ? ({1'b0, s2} + {1'b0, nx2_reg}) : '0;
        end
    end

    assign ge = ge_reg;

    pcfk_isqrt u_sqrt (
        .clk  (clk),
        .adv  (adv),
        .val  ({{(pcfk_pkg::SQRT_IN_W - pcfk_pkg::ARG_W - 2*pcfk_pkg::FRAC_BITS){1'b0}},
                arg_reg, {(2*pcfk_pkg::FRAC_BITS){1'b0}}}),
        .root (root)
    );

endmodule

`default_nettype wire

// File: hdl/pcfk_div.sv
// Pipelined restoring divider for the Q0.16 ratio, one quotient bit per stage.
`default_nettype none

module pcfk_div (
    input  wire logic                         clk,
    input  wire logic                         adv,
    input  wire logic [pcfk_pkg::NUM_W-1:0]   num,
    input  wire logic [pcfk_pkg::NA_W-1:0]    den,
    output logic      [pcfk_pkg::PC_W-1:0]    quo,
    output logic                              zero,
    output logic                              sat
);

    localparam int R_W = pcfk_pkg::NA_W;

    logic [R_W-1:0]              d0_reg;
    logic [R_W-1:0]              r0_reg;
    logic                        z0_reg;
    logic                        s0_reg;

    logic [R_W-1:0]              d_reg [pcfk_pkg::DIV_STEPS];
    logic [R_W-1:0]              r_reg [pcfk_pkg::DIV_STEPS];
    logic [pcfk_pkg::PC_W-1:0]   q_reg [pcfk_pkg::DIV_STEPS];
    logic                        z_reg [pcfk_pkg::DIV_STEPS];
    logic                        s_reg [pcfk_pkg::DIV_STEPS];

    // A numerator at or above the divisor gives a ratio of one or more.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_reg <= den;
            r0_reg <= R_W'(num);
            z0_reg <= (den == '0);
            s0_reg <= (R_W'(num) >= den);
        end
    end

    for (genvar j = 0; j < pcfk_pkg::DIV_STEPS; j++) begin : g_step
        logic [R_W-1:0]            d_in;
        logic [R_W-1:0]            r_in;
        logic [pcfk_pkg::PC_W-1:0] q_in;
        logic                      z_in;
        logic                      s_in;
        logic [R_W:0]              r2;
        logic                      fit;

        if (j == 0) begin : g_first
            assign d_in = d0_reg;
            assign r_in = r0_reg;
            assign q_in = '0;
            assign z_in = z0_reg;
            assign s_in = s0_reg;
        end
        else begin : g_next
            assign d_in = d_reg[j-1];
            assign r_in = r_reg[j-1];
            assign q_in = q_reg[j-1];
            assign z_in = z_reg[j-1];
            assign s_in = s_reg[j-1];
        end

        assign r2  = {r_in, 1'b0};
        assign fit = (r2 >= {1'b0, d_in});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[j] <= d_in;
                r_reg[j] <= fit ? R_W'(r2 - {1'b0, d_in}) : r2[R_W-1:0];
                q_reg[j] <= {q_in[pcfk_pkg::PC_W-2:0], fit};
                z_reg[j] <= z_in;
                s_reg[j] <= s_in;
            end
        end
    end

    assign quo  = q_reg[pcfk_pkg::DIV_STEPS-1];
    assign zero = z_reg[pcfk_pkg::DIV_STEPS-1];
    assign sat  = s_reg[pcfk_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

// File: hdl/phase_congruency_from_kernels.sv
// Top level of the phase congruency block: lanes, merge, divider and output buffer.
//
// Usage: each transfer on the item channel carries one voxel, the responses of
// up to eight reconstruction kernels (resp_a upward) and an optional gradient.
// Each item gives exactly one transfer on the result channel, in order: pc_all
// is the phase congruency in unsigned Q0.16, and pc_up or pc_down repeats it
// when the gradient is present and positive or present and not positive.
// Throughput is one item per cycle while the skid register is empty; the
// depth comes from the 30 stages of the bit-per-stage square root units and
// the 16 stages of the quotient pipeline. The APB port sets active_kernels
// and noise_level, and must only be written while no item is in flight.
// Reset clears all valid flags, including those of the output buffer, and loads
// active_kernels with 8 and noise_level with 0. When the receiver stalls, the finished result
// stays in the output register and the next one moves into a skid register;
// only when that register is full does the pipeline freeze and ready drop.
`default_nettype none

module phase_congruency_from_kernels (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    pcfk_in_if.sink                                item,
    pcfk_out_if.source                             result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pcfk_pkg::CFG_AW-1:0]       paddr,
    input  wire logic [pcfk_pkg::CFG_DW-1:0]       pwdata,
    output logic      [pcfk_pkg::CFG_DW-1:0]       prdata,
    output logic                                   pready
);

    localparam int LANES  = pcfk_pkg::LANES;
    localparam int KW     = pcfk_pkg::KCNT_W;
    localparam int SW     = pcfk_pkg::SAMPLE_W;
    localparam int PSUM_N = LANES / 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [KW-1:0] act_reg;
    logic [15:0]   noise_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= pcfk_pkg::ACTIVE_RESET;
            noise_reg <= pcfk_pkg::NOISE_RESET;
        end
        else if (cfg_wr)
        begin
            case (pcfk_pkg::cfg_reg_t'(paddr[2]))
                pcfk_pkg::REG_ACTIVE: act_reg   <= pwdata[KW-1:0];
                pcfk_pkg::REG_NOISE:  noise_reg <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (pcfk_pkg::cfg_reg_t'(paddr[2]))
            pcfk_pkg::REG_ACTIVE: prdata = {{(pcfk_pkg::CFG_DW-KW){1'b0}}, act_reg};
            pcfk_pkg::REG_NOISE:  prdata = {{(pcfk_pkg::CFG_DW-16){1'b0}}, noise_reg};
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the skid
    // register is occupied, so ready is a plain register output.
    // ------------------------------------------------------------------
    logic                         adv;
    logic [pcfk_pkg::NSTAGES-1:0] v_reg;
    logic                         out_v_reg;
    logic                         skid_v_reg;

    assign adv        = !skid_v_reg;
    assign item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[pcfk_pkg::NSTAGES-2:0], item.valid};
    end

    // ------------------------------------------------------------------
    // Input stage: clamp the lane count, scale the noise floor, sort the
    // gradient, and zero the lanes that are not in use.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] x_in [LANES];
    logic [KW-1:0]        n_clamp;
    logic [19:0]          noise_mul;
    logic                 grad_pos;
    pcfk_pkg::side_t      side_in;

    assign x_in[0] = item.resp_a;
    assign x_in[1] = item.resp_b;
    assign x_in[2] = item.resp_c;
    assign x_in[3] = item.resp_d;
    assign x_in[4] = item.resp_e;
    assign x_in[5] = item.resp_f;
    assign x_in[6] = item.resp_g;
    assign x_in[7] = item.resp_h;

    always_comb
    begin
        if (act_reg < KW'(pcfk_pkg::MIN_KERNELS))
            n_clamp = KW'(pcfk_pkg::MIN_KERNELS);
        else if (act_reg > KW'(pcfk_pkg::MAX_KERNELS))
            n_clamp = KW'(pcfk_pkg::MAX_KERNELS);
        else
            n_clamp = act_reg;
    end

    assign noise_mul    = {16'd0, n_clamp} * {4'd0, noise_reg};
    assign grad_pos     = (item.grad_value > 16'sd0);
    assign side_in.sub  = {noise_mul[18:0], {pcfk_pkg::FRAC_BITS{1'b0}}};
    assign side_in.up   = item.grad_present && grad_pos;
    assign side_in.down = item.grad_present && !grad_pos;

    logic signed [SW-1:0] x0_reg [LANES];
    logic [KW-1:0]        n0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < LANES; i++)
                x0_reg[i] <= (KW'(i) < n_clamp) ? x_in[i] : '0;
            n0_reg <= n_clamp;
        end
    end

    // Side values follow their item down the whole pipeline.
    pcfk_pkg::side_t side_reg [pcfk_pkg::NSTAGES];

    for (genvar k = 0; k < pcfk_pkg::NSTAGES; k++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k-1];
        end
    end

    // ------------------------------------------------------------------
    // Sum of the active responses.
    // ------------------------------------------------------------------
    logic signed [pcfk_pkg::SUM_W-1:0] s_sum;
    logic signed [pcfk_pkg::SUM_W-1:0] s1_reg;
    logic signed [SW-1:0]              x1_reg [LANES];
    logic [KW-1:0]                     n1_reg;

    always_comb
    begin
        s_sum = '0;
        for (int i = 0; i < LANES; i++)
            s_sum = s_sum + pcfk_pkg::SUM_W'(x0_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s_sum;
            x1_reg <= x0_reg;
            n1_reg <= n0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Global terms: |S|, S squared and the squared mean-comparison factor.
    // ------------------------------------------------------------------
    logic [pcfk_pkg::MAG_W-1:0]   sabs;
    logic [pcfk_pkg::MAG_W-1:0]   sabs_reg;
    logic [KW-1:0]                n2_reg;
    logic [2*pcfk_pkg::MAG_W-1:0] s_sq_full;
    logic [pcfk_pkg::SQ_W-1:0]    s2sq_reg;
    logic [LANES-1:0]             ge_vec;
    logic [KW-1:0]                ge_cnt;
    logic [KW:0]                  two_cnt;
    logic [KW:0]                  kd_abs;
    logic [2*KW+1:0]              kd_sq;
    logic [2*KW+1:0]              n_sq;
    logic [2*KW+1:0]              k2_full;
    logic [pcfk_pkg::K2_W-1:0]    k2_reg;

    assign sabs      = s1_reg[pcfk_pkg::SUM_W-1] ? (~s1_reg + pcfk_pkg::SUM_W'(1)) : s1_reg;
    assign s_sq_full = {{pcfk_pkg::MAG_W{1'b0}}, sabs_reg} * {{pcfk_pkg::MAG_W{1'b0}}, sabs_reg};
    assign ge_cnt    = KW'($countones(ge_vec));
    assign two_cnt   = {ge_cnt, 1'b0};
    assign kd_abs    = (two_cnt >= {1'b0, n2_reg}) ? (two_cnt - {1'b0, n2_reg})
                                                   : ({1'b0, n2_reg} - two_cnt);
    assign kd_sq     = {{(KW+1){1'b0}}, kd_abs} * {{(KW+1){1'b0}}, kd_abs};
    assign n_sq      = {{(KW+2){1'b0}}, n2_reg} * {{(KW+2){1'b0}}, n2_reg};
    assign k2_full   = kd_sq + n_sq;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sabs_reg <= sabs;
            n2_reg   <= n1_reg;
            s2sq_reg <= s_sq_full[pcfk_pkg::SQ_W-1:0];
            k2_reg   <= k2_full[pcfk_pkg::K2_W-1:0];
        end
    end

    // n^2 F^2 argument: S^2 * (k^2 + n^2), then its root.
    logic [pcfk_pkg::SQ_W+pcfk_pkg::K2_W-1:0] fa_full;
    logic [pcfk_pkg::FA_W-1:0]                fa_reg;
    logic [pcfk_pkg::SQRT_OUT_W-1:0]          f_root;

    assign fa_full = {{pcfk_pkg::K2_W{1'b0}}, s2sq_reg} * {{pcfk_pkg::SQ_W{1'b0}}, k2_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
            fa_reg <= fa_full[pcfk_pkg::FA_W-1:0];
    end

    pcfk_isqrt u_f_sqrt (
        .clk  (clk),
        .adv  (adv),
        .val  ({fa_reg, {(2*pcfk_pkg::FRAC_BITS){1'b0}}}),
        .root (f_root)
    );

    // ------------------------------------------------------------------
    // Kernel lanes.
    // ------------------------------------------------------------------
    logic [pcfk_pkg::SQRT_OUT_W-1:0] lane_root [LANES];

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        pcfk_lane u_lane (
            .clk    (clk),
            .adv    (adv),
            .active (KW'(i) < n1_reg),
            .n      (n1_reg),
            .x      (x1_reg[i]),
            .s      (s1_reg),
            .s2     (s2sq_reg),
            .ge     (ge_vec[i]),
            .root   (lane_root[i])
        );
    end

    // ------------------------------------------------------------------
    // Merge: add the lane energies in a two-level tree and take the
    // noise floor off the local energy.
    // ------------------------------------------------------------------
    logic [pcfk_pkg::NA_W-1:0]  psum_reg [PSUM_N];
    logic [pcfk_pkg::NUM_W-1:0] num1_reg;
    logic [pcfk_pkg::NA_W-1:0]  psum_tot;
    logic [pcfk_pkg::NA_W-1:0]  na_reg;
    logic [pcfk_pkg::NUM_W-1:0] num2_reg;
    logic [pcfk_pkg::NUM_W-1:0] sub_ext;

    assign sub_ext = pcfk_pkg::NUM_W'(side_reg[pcfk_pkg::ST_ADD1-1].sub);

    always_comb
    begin
        psum_tot = '0;
        for (int i = 0; i < PSUM_N; i++)
            psum_tot = psum_tot + psum_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < PSUM_N; i++)
                psum_reg[i] <= lane_root[2*i] + lane_root[2*i+1];
            num1_reg <= (f_root > sub_ext) ? (f_root - sub_ext) : '0;
            na_reg   <= psum_tot;
            num2_reg <= num1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Ratio and output buffer.
    // ------------------------------------------------------------------
    logic [pcfk_pkg::PC_W-1:0] quo;
    logic                      div_zero;
    logic                      div_sat;
    logic [pcfk_pkg::PC_W-1:0] pc_new;
    pcfk_pkg::side_t           side_last;

    pcfk_div u_div (
        .clk  (clk),
        .adv  (adv),
        .num  (num2_reg),
        .den  (na_reg),
        .quo  (quo),
        .zero (div_zero),
        .sat  (div_sat)
    );

    assign side_last = side_reg[pcfk_pkg::ST_LAST];
    assign pc_new    = div_zero ? '0 : (div_sat ? '1 : quo);

    logic                      push;
    logic                      pop;
    logic [pcfk_pkg::PC_W-1:0] out_all_reg;
    logic [pcfk_pkg::PC_W-1:0] out_up_reg;
    logic [pcfk_pkg::PC_W-1:0] out_down_reg;
    logic [pcfk_pkg::PC_W-1:0] skid_all_reg;
    logic [pcfk_pkg::PC_W-1:0] skid_up_reg;
    logic [pcfk_pkg::PC_W-1:0] skid_down_reg;
    logic [pcfk_pkg::PC_W-1:0] new_up;
    logic [pcfk_pkg::PC_W-1:0] new_down;

    assign push     = adv && v_reg[pcfk_pkg::ST_LAST];
    assign pop      = out_v_reg && result.ready;
    assign new_up   = side_last.up   ? pc_new : '0;
    assign new_down = side_last.down ? pc_new : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || pop)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= push;
        end
        else if (push)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || pop)
        begin
            if (skid_v_reg)
            begin
                out_all_reg  <= skid_all_reg;
                out_up_reg   <= skid_up_reg;
                out_down_reg <= skid_down_reg;
            end
            else
            begin
                out_all_reg  <= pc_new;
                out_up_reg   <= new_up;
                out_down_reg <= new_down;
            end
        end
        else if (push)
        begin
            skid_all_reg  <= pc_new;
            skid_up_reg   <= new_up;
            skid_down_reg <= new_down;
        end
    end

    assign result.valid   = out_v_reg;
    assign result.pc_all  = out_all_reg;
    assign result.pc_up   = out_up_reg;
    assign result.pc_down = out_down_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_up_down_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.pc_up == '0 || result.pc_down == '0))
        else $error("pc_up and pc_down both nonzero");

    a_up_copies_all: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.pc_up != '0) |-> (result.pc_up == result.pc_all))
        else $error("pc_up differs from pc_all");

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register holds a transfer while the output is empty");

    a_lane_count: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[pcfk_pkg::ST_IN] |->
            (n0_reg >= KW'(pcfk_pkg::MIN_KERNELS) && n0_reg <= KW'(pcfk_pkg::MAX_KERNELS)))
        else $error("lane count outside its clamped range");

endmodule

`default_nettype wire
